[design/modular_exponentiation_assert.svh]
// Assertion macros used by the modular exponentiation checker.
// Needs nothing else; the user supplies clock and reset names.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MEXP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MEXP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mexp_pkg.sv]
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by the top level and the multiply/reduce unit.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

   localparam int unsigned MODULUS_BITS     = 32;
   localparam int unsigned DATA_WIDTH       = 32;
   localparam int unsigned PRODUCT_WIDTH    = DATA_WIDTH + MODULUS_BITS;
   localparam int unsigned LOW_ALIGN        = DATA_WIDTH - MODULUS_BITS;
   localparam int unsigned STEP_COUNT_WIDTH = $clog2(DATA_WIDTH + 1);

   typedef logic [MODULUS_BITS-1:0] residue_type;
   typedef logic [DATA_WIDTH-1:0]   data_type;

   // Command from the sequencer to the multiply/reduce unit.
   typedef struct packed {
      logic start;
      logic reduce_only;
   } unit_cmd_type;

   // Status back from the unit.
   typedef struct packed {
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

[design/modular_exponentiation.sv]
// Modular exponentiation: rsp_power_mod = req_base ** req_exponent mod n, n set through
// the csr port (reset value 2; a modulus of 0 or 1 gives 0). One transaction is in work
// at a time and req_stall stays high until its result has moved to the output register.
// All arithmetic runs on one shared multiply/reduce unit: the base reduction takes 32
// remainder steps and every square or multiply takes one multiply step, 32 remainder
// steps and one handoff. Squaring stops after the highest set exponent bit, so the time
// for an item grows with the number of squares and set bits.
// Write the modulus only while no transaction is in work.
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [31:0]                  csr_modulus,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [31:0]                  req_base,
   input  wire logic [31:0]                  req_exponent,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [31:0]                       rsp_power_mod
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_BASE   = 5'b00010,
      S_MULT   = 5'b00100,
      S_SQUARE = 5'b01000,
      S_FINISH = 5'b10000
   } seq_state_type;

   seq_state_type              state_ff, state_in;
   mexp_pkg::residue_type      modulus_ff;
   mexp_pkg::residue_type      acc_ff, acc_in;
   mexp_pkg::residue_type      sq_ff, sq_in;
   mexp_pkg::data_type         exp_ff, exp_in;
   mexp_pkg::data_type         exp_shift;
   logic                       rsp_valid_ff;
   logic [31:0]                rsp_power_mod_ff;
   logic                       rsp_load;
   logic                       out_free;

   mexp_pkg::unit_cmd_type     unit_cmd;
   mexp_pkg::unit_status_type  unit_status;
   mexp_pkg::data_type         unit_a;
   mexp_pkg::residue_type      unit_b;
   mexp_pkg::residue_type      unit_result;

   mexp_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .cmd       (unit_cmd),
      .operand_a (unit_a),
      .operand_b (unit_b),
      .modulus   (modulus_ff),
      .status    (unit_status),
      .result    (unit_result)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign exp_shift = exp_ff >> 1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      exp_in   = exp_ff;
      unit_cmd = '0;
      unit_a   = mexp_pkg::DATA_WIDTH'(sq_ff);
      unit_b   = sq_ff;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               exp_in = req_exponent;
               if (modulus_ff < mexp_pkg::MODULUS_BITS'(2)) begin
                  acc_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  unit_cmd.start       = 1'b1;
                  unit_cmd.reduce_only = 1'b1;
                  unit_a               = req_base;
                  state_in             = S_BASE;
               end
            end
         end
         S_BASE: begin
            if (unit_status.done) begin
               sq_in  = unit_result;
               acc_in = mexp_pkg::MODULUS_BITS'(1);
               if (exp_ff == '0) begin
                  state_in = S_FINISH;
               end else if (exp_ff[0]) begin
                  unit_cmd.start = 1'b1;
                  unit_a         = mexp_pkg::DATA_WIDTH'(1);
                  unit_b         = unit_result;
                  state_in       = S_MULT;
               end else begin
                  unit_cmd.start = 1'b1;
                  unit_a         = mexp_pkg::DATA_WIDTH'(unit_result);
                  unit_b         = unit_result;
                  state_in       = S_SQUARE;
               end
            end
         end
         S_MULT: begin
            if (unit_status.done) begin
               acc_in = unit_result;
               // no set bits left: the remaining squares would go unused
               if (exp_shift == '0) begin
                  state_in = S_FINISH;
               end else begin
                  unit_cmd.start = 1'b1;
                  state_in       = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            if (unit_status.done) begin
               sq_in          = unit_result;
               exp_in         = exp_shift;
               unit_cmd.start = 1'b1;
               if (exp_shift[0]) begin
                  unit_a   = mexp_pkg::DATA_WIDTH'(acc_ff);
                  unit_b   = unit_result;
                  state_in = S_MULT;
               end else begin
                  unit_a   = mexp_pkg::DATA_WIDTH'(unit_result);
                  unit_b   = unit_result;
                  state_in = S_SQUARE;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= mexp_pkg::MODULUS_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_modulus[mexp_pkg::MODULUS_BITS-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      exp_ff <= exp_in;
      if (rsp_load) begin
         rsp_power_mod_ff <= 32'(acc_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_power_mod_ff;

endmodule

`default_nettype wire

[design/mexp_mulmod.sv]
// Shared multiply and reduce unit: a * b mod n, or a mod n alone.
// A registered multiply (skipped for a mod n alone), then one restoring remainder step per cycle.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mexp_pkg::unit_cmd_type  cmd,
   input  wire mexp_pkg::data_type      operand_a,
   input  wire mexp_pkg::residue_type   operand_b,
   input  wire mexp_pkg::residue_type   modulus,
   output mexp_pkg::unit_status_type    status,
   output mexp_pkg::residue_type        result
);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_RED  = 3'b100
   } unit_state_type;

   unit_state_type                              state_ff, state_in;
   logic [mexp_pkg::PRODUCT_WIDTH-1:0]          prod_ff, prod_in;
   mexp_pkg::residue_type                       rem_ff, rem_in;
   mexp_pkg::data_type                          low_ff, low_in;
   logic [mexp_pkg::STEP_COUNT_WIDTH-1:0]       count_ff, count_in;
   logic                                        done_ff, done_in;

   // One remainder step: shift in the next bit, subtract n if it fits.
   logic [mexp_pkg::MODULUS_BITS:0]             trial;
   logic [mexp_pkg::MODULUS_BITS:0]             trial_sub;

   assign trial     = {rem_ff, low_ff[mexp_pkg::DATA_WIDTH-1]};
   assign trial_sub = trial - {1'b0, modulus};

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               if (cmd.reduce_only) begin
                  rem_in   = '0;
                  low_in   = operand_a;
                  count_in = mexp_pkg::STEP_COUNT_WIDTH'(mexp_pkg::DATA_WIDTH);
                  state_in = U_RED;
               end else begin
                  prod_in  = mexp_pkg::PRODUCT_WIDTH'(operand_a)
                           * mexp_pkg::PRODUCT_WIDTH'(operand_b);
                  state_in = U_MUL;
               end
            end
         end
         U_MUL: begin
            // Both factors are below n, so the high half is already below n.
            rem_in   = prod_ff[mexp_pkg::MODULUS_BITS +: mexp_pkg::MODULUS_BITS];
            low_in   = mexp_pkg::DATA_WIDTH'(prod_ff[mexp_pkg::MODULUS_BITS-1:0])
                       << mexp_pkg::LOW_ALIGN;
            count_in = mexp_pkg::STEP_COUNT_WIDTH'(mexp_pkg::MODULUS_BITS);
            state_in = U_RED;
         end
         U_RED: begin
            if (trial >= {1'b0, modulus}) begin
               rem_in = trial_sub[mexp_pkg::MODULUS_BITS-1:0];
            end else begin
               rem_in = trial[mexp_pkg::MODULUS_BITS-1:0];
            end
            low_in   = low_ff << 1;
            count_in = count_ff - mexp_pkg::STEP_COUNT_WIDTH'(1);
            if (count_ff == mexp_pkg::STEP_COUNT_WIDTH'(1)) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      count_ff <= count_in;
   end

   assign status.done = done_ff;
   assign result      = rem_ff;

endmodule

`default_nettype wire

[design/mexp_checker.sv]
// Port-level checks for modular_exponentiation, bound to the top level.
// Depends on modular_exponentiation_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_assert.svh"

module mexp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [31:0]  rsp_power_mod
);

   // held result must not change or drop while stalled
   `MEXP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_mod), "result changed while stalled")

   // no result can be pending out of reset
   `MEXP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // one transaction at a time: the input side closes right after an accept
   `MEXP_ASSERT(a_req_busy, clock, reset, req_valid && !req_stall |=> req_stall, "input accepted while busy")

   // a new result only comes out of a transaction in work
   `MEXP_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "result without a transaction")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire

[verif/modular_exponentiation_tb.sv]
// Self-checking testbench for modular_exponentiation: directed table, then random traffic.
// Results come from the directed table or from a square-and-multiply model kept in the bench.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

   localparam int HOLD_CYCLES   = 4000;
   localparam int STALL_LIMIT   = 20000;
   localparam int ITEMS_PER_SET = 30;
   localparam int SETS_PER_LOOP = 3;
   localparam int ROW_COUNT     = 28;

   typedef enum bit {ROW_ITEM, ROW_MODULUS} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  a;        // base, or modulus for a write row
      logic [31:0]  b;        // exponent
      bit           fixed;    // expected value is typed in
      logic [31:0]  want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_modulus;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_base;
   logic [31:0] req_exponent;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_power_mod;

   logic [31:0] model_modulus;
   logic [31:0] power_mod_queue[$];
   int          failure_count = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_armed    = 1'b0;
   bit          hold_taken    = 1'b0;
   int          hold_left     = 0;

   directed_row_type directed_rows [ROW_COUNT] = '{
      // reset modulus is 2
      '{ROW_ITEM,    32'd5,          32'd0,          1'b1, 32'd1},
      '{ROW_ITEM,    32'd3,          32'd1,          1'b1, 32'd1},
      '{ROW_ITEM,    32'd4,          32'd7,          1'b1, 32'd0},
      '{ROW_ITEM,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1},
      '{ROW_MODULUS, 32'hFFFF_FFFF,  32'd0,          1'b0, 32'd0},
      '{ROW_ITEM,    32'd0,          32'd0,          1'b1, 32'd1},
      '{ROW_ITEM,    32'd0,          32'd5,          1'b1, 32'd0},
      '{ROW_ITEM,    32'd1,          32'hFFFF_FFFF,  1'b1, 32'd1},
      '{ROW_ITEM,    32'hFFFF_FFFF,  32'd1,          1'b1, 32'd0},
      '{ROW_ITEM,    32'hFFFF_FFFE,  32'd2,          1'b1, 32'd1},
      '{ROW_ITEM,    32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFE},
      '{ROW_ITEM,    32'h1234_5678,  32'hFFFF_FFFF,  1'b0, 32'd0},
      '{ROW_ITEM,    32'hDEAD_BEEF,  32'h8000_0000,  1'b0, 32'd0},
      // modulus below two gives zero
      '{ROW_MODULUS, 32'd0,          32'd0,          1'b0, 32'd0},
      '{ROW_ITEM,    32'd7,          32'd3,          1'b1, 32'd0},
      '{ROW_ITEM,    32'd0,          32'd0,          1'b1, 32'd0},
      '{ROW_ITEM,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
      '{ROW_MODULUS, 32'd1,          32'd0,          1'b0, 32'd0},
      '{ROW_ITEM,    32'd9,          32'd0,          1'b1, 32'd0},
      '{ROW_ITEM,    32'hFFFF_FFFF,  32'd5,          1'b1, 32'd0},
      // n = 61 * 53, e = 17, d = 2753
      '{ROW_MODULUS, 32'd3233,       32'd0,          1'b0, 32'd0},
      '{ROW_ITEM,    32'd65,         32'd17,         1'b1, 32'd2790},
      '{ROW_ITEM,    32'd2790,       32'd2753,       1'b1, 32'd65},
      '{ROW_ITEM,    32'd3233,       32'd5,          1'b1, 32'd0},
      '{ROW_ITEM,    32'd3234,       32'd9,          1'b1, 32'd1},
      '{ROW_ITEM,    32'd123,        32'd0,          1'b1, 32'd1},
      '{ROW_MODULUS, 32'd2,          32'd0,          1'b0, 32'd0},
      '{ROW_ITEM,    32'hAAAA_AAAA,  32'h5555_5555,  1'b1, 32'd0}
   };

   modular_exponentiation dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_modulus   (csr_modulus),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_power_mod (rsp_power_mod)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] predict_power_mod(logic [31:0] b, logic [31:0] e,
                                                     logic [31:0] n);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] nn;
      nn = {32'd0, n};
      if (nn < 64'd2) return 32'd0;
      acc = 64'd1 % nn;
      sq  = {32'd0, b} % nn;
      for (int i = 0; i < 32; i++) begin
         if (e[i]) acc = (acc * sq) % nn;
         sq = (sq * sq) % nn;
      end
      return acc[31:0];
   endfunction

   // valid stays high from one transaction to the next unless a gap is rolled
   task automatic push_request(input logic [31:0] b, input logic [31:0] e,
                               input logic [31:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= b;
      req_exponent <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      power_mod_queue.push_back(want);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (power_mod_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [31:0] value);
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_modulus = 32'(({32'd0, value}) & ((64'd1 << mexp_pkg::MODULUS_BITS) - 64'd1));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stall, plus one long hold-off when armed.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (power_mod_queue.size() == 0) begin
            $error("power_mod: unexpected transaction, actual %h", rsp_power_mod);
            failure_count++;
         end else if (rsp_power_mod !== power_mod_queue[0]) begin
            $error("power_mod: expected %h, actual %h", power_mod_queue[0], rsp_power_mod);
            failure_count++;
            void'(power_mod_queue.pop_front());
         end else begin
            void'(power_mod_queue.pop_front());
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      logic [31:0]      b_val;
      logic [31:0]      e_val;
      logic [31:0]      n_val;

      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_modulus   = 32'd0;
      req_valid     = 1'b0;
      req_base      = 32'd0;
      req_exponent  = 32'd0;
      model_modulus = 32'd2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < ROW_COUNT; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_MODULUS) begin
            drain_results();
            write_modulus(row.a);
         end else begin
            push_request(row.a, row.b,
                         row.fixed ? row.want : predict_power_mod(row.a, row.b, model_modulus));
         end
      end

      for (int loop = 0; loop < 3; loop++) begin
         case (loop)
            0: begin send_idle_pct = 31; recv_idle_pct = 87; end
            1: begin send_idle_pct = 87; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int k = 0; k < ITEMS_PER_SET * SETS_PER_LOOP; k++) begin
            if (k % ITEMS_PER_SET == 0) begin
               // sender waits out every pending result before the modulus changes
               drain_results();
               case ($urandom_range(7))
                  0: begin
                     case ($urandom_range(3))
                        0: n_val = 32'd0;
                        1: n_val = 32'd1;
                        2: n_val = 32'd2;
                        default: n_val = 32'hFFFF_FFFF;
                     endcase
                  end
                  1, 2, 3: n_val = $urandom_range(65535, 2);
                  default: n_val = $urandom;
               endcase
               write_modulus(n_val);
               // long receiver hold-off while the sender keeps offering
               if (loop == 2 && k == 0) hold_armed = 1'b1;
            end
            case ($urandom_range(3))
               0, 3: b_val = $urandom;
               1: b_val = $urandom_range(255, 0);
               default: b_val = model_modulus + $urandom_range(2, 0) - 32'd1;
            endcase
            // most exponents are short to keep the run time down
            case ($urandom_range(7))
               0, 1: e_val = $urandom;
               2: e_val = 32'd0;
               3: e_val = 32'hFFFF_FFFF;
               default: e_val = $urandom & ((32'd1 << $urandom_range(12, 1)) - 32'd1);
            endcase
            push_request(b_val, e_val, predict_power_mod(b_val, e_val, model_modulus));
         end
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[modular_exponentiation.f]
+incdir+design
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation.sv
design/mexp_checker.sv
verif/modular_exponentiation_tb.sv
